// ===== rtl/core/cvq_pkg.sv =====
// ----------------------------------------------------------------------------
// Color-block VQ decoder package
// Shared widths, register indexes, block command types and color helpers.
// ----------------------------------------------------------------------------
package cvq_pkg;

    localparam int CFG_W       = 10;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_MAX     = 1023;
    localparam int POS_W       = 11;
    localparam int SKIP_W      = 10;
    localparam int COORD_W     = 11;
    localparam int VALUE_W     = 24;
    localparam int NUM_COLORS  = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_BLOCKS_WIDE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCKS_HIGH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_MODE  = 2'd2;

    localparam logic [5:0] SKIP_PREFIX   = 6'b100001;
    localparam logic [7:0] EIGHT_CODE_HI = 8'h90;

    typedef enum logic [1:0] {
        KIND_FILL,
        KIND_TWO,
        KIND_EIGHT
    } t_kind;

    typedef struct packed {
        t_kind                               kind;
        logic                                mode;
        logic [15:0]                         flags;
        logic [VALUE_W-1:0]                  fill;
        logic [NUM_COLORS-1:0][15:0]         colors;
        logic [COORD_W-1:0]                  xbase;
        logic [COORD_W-1:0]                  ybase;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_push;

    function automatic logic [VALUE_W-1:0] widen555(input logic [15:0] c);
        return {c[14:10], 3'b000, c[9:5], 3'b000, c[4:0], 3'b000};
    endfunction

endpackage

// ===== rtl/core/cvq_front.sv =====
// ----------------------------------------------------------------------------
// Color-block VQ decoder front end
// Holds the configuration, parses the byte stream, tracks the block position
// and hands one command per decoded block to the command queue.
// ----------------------------------------------------------------------------
module cvq_front import cvq_pkg::*; #(
    parameter int MAX_BLOCKS_WIDE = 512,
    parameter int MAX_BLOCKS_HIGH = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_push,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_frame_start,
    output logic                  o_full,
    input  logic                  i_q_full,
    output t_cmd_push             o_cmd_push
);

    localparam int MaxWide = (MAX_BLOCKS_WIDE > CFG_MAX) ? CFG_MAX : MAX_BLOCKS_WIDE;
    localparam int MaxHigh = (MAX_BLOCKS_HIGH > CFG_MAX) ? CFG_MAX : MAX_BLOCKS_HIGH;
    localparam logic [CFG_W-1:0] MaxWideC = CFG_W'(MaxWide);
    localparam logic [CFG_W-1:0] MaxHighC = CFG_W'(MaxHigh);

    typedef enum logic [1:0] {
        PH_CODE_LO,
        PH_CODE_HI,
        PH_COLORS,
        PH_SKIP
    } t_phase;

    logic [CFG_W-1:0]  r_blocks_wide;
    logic [CFG_W-1:0]  r_blocks_high;
    logic              r_pixel_mode;
    t_phase            r_phase, n_phase;
    logic [3:0]        r_k, n_k;
    logic [15:0]       r_code, n_code;
    logic [POS_W-1:0]  r_col, n_col;
    logic [POS_W-1:0]  r_row, n_row;
    logic [SKIP_W-1:0] r_skip, n_skip;
    logic              r_active, n_active;
    logic [NUM_COLORS-1:0][15:0] r_colors, n_colors;

    logic [CFG_W-1:0]  w_wide_c;
    logic [CFG_W-1:0]  w_high_c;
    logic [POS_W-1:0]  w_eff_w;
    logic [POS_W-1:0]  w_eff_h;
    logic              w_take;

    logic              adv_en;
    logic [SKIP_W-1:0] adv_n;
    logic [POS_W-1:0]  adv_rem;
    logic [POS_W-1:0]  adv_col;
    logic [POS_W-1:0]  adv_row;
    logic [SKIP_W-1:0] adv_rest;
    logic              adv_drop;

    t_cmd_push         w_push;

    always_comb begin
        w_wide_c = r_blocks_wide;
        if (r_blocks_wide == '0) begin
            w_wide_c = CFG_W'(1);
        end else if (r_blocks_wide > MaxWideC) begin
            w_wide_c = MaxWideC;
        end
        w_high_c = r_blocks_high;
        if (r_blocks_high == '0) begin
            w_high_c = CFG_W'(1);
        end else if (r_blocks_high > MaxHighC) begin
            w_high_c = MaxHighC;
        end
    end

    assign w_eff_w = POS_W'(w_wide_c);
    assign w_eff_h = POS_W'(w_high_c);
    assign o_full  = (r_phase == PH_SKIP) || i_q_full;
    assign w_take  = i_push && !o_full;

    // Advances the block position by up to one block row per cycle.
    always_comb begin
        adv_rem  = (r_col >= w_eff_w) ? POS_W'(1) : (w_eff_w - r_col);
        adv_col  = r_col;
        adv_row  = r_row;
        adv_rest = '0;
        adv_drop = 1'b0;
        if (adv_en) begin
            if (POS_W'(adv_n) >= adv_rem) begin
                adv_col  = '0;
                adv_row  = r_row + POS_W'(1);
                adv_rest = adv_n - SKIP_W'(adv_rem);
                adv_drop = (r_row + POS_W'(1)) >= w_eff_h;
            end else begin
                adv_col = r_col + POS_W'(adv_n);
            end
        end
    end

    always_comb begin
        logic              v_active;
        t_phase            v_phase;
        logic [POS_W-1:0]  v_col;
        logic [POS_W-1:0]  v_row;
        logic [15:0]       v_code;
        logic [4:0]        v_k_new;
        logic [4:0]        v_need;
        t_kind             v_kind;
        logic [POS_W-1:0]  v_yrow;

        n_phase  = r_phase;
        n_k      = r_k;
        n_code   = r_code;
        n_col    = r_col;
        n_row    = r_row;
        n_skip   = r_skip;
        n_active = r_active;
        n_colors = r_colors;
        adv_en   = 1'b0;
        adv_n    = '0;
        v_code   = {i_data_byte, r_code[7:0]};
        v_k_new  = 5'(r_k) + 5'd1;
        v_need   = 5'd4;
        v_kind   = KIND_TWO;
        v_yrow   = w_eff_h - POS_W'(1) - r_row;
        v_active = i_frame_start ? 1'b1 : r_active;
        v_phase  = i_frame_start ? PH_CODE_LO : r_phase;
        v_col    = i_frame_start ? '0 : r_col;
        v_row    = i_frame_start ? '0 : r_row;

        w_push.valid        = 1'b0;
        w_push.cmd.kind     = KIND_FILL;
        w_push.cmd.mode     = r_pixel_mode;
        w_push.cmd.flags    = r_code;
        w_push.cmd.fill     = '0;
        w_push.cmd.colors   = r_colors;
        w_push.cmd.xbase    = {r_col[COORD_W-3:0], 2'b00};
        w_push.cmd.ybase    = {v_yrow[COORD_W-3:0], 2'b00};

        if (r_phase == PH_SKIP) begin
            adv_en = 1'b1;
            adv_n  = r_skip;
            n_col  = adv_col;
            n_row  = adv_row;
            n_skip = adv_rest;
            if (adv_drop) begin
                n_active = 1'b0;
            end
            if (adv_drop || (adv_rest == '0)) begin
                n_phase = PH_CODE_LO;
            end
        end else if (w_take) begin
            if (i_frame_start) begin
                n_phase  = PH_CODE_LO;
                n_code   = '0;
                n_col    = '0;
                n_row    = '0;
                n_active = 1'b1;
            end
            if (v_active) begin
                case (v_phase)
                    PH_CODE_LO: begin
                        if (v_col >= w_eff_w) begin
                            v_col = '0;
                            v_row = v_row + POS_W'(1);
                        end
                        n_col = v_col;
                        n_row = v_row;
                        if (v_row >= w_eff_h) begin
                            n_active = 1'b0;
                        end else begin
                            n_code  = {8'h00, i_data_byte};
                            n_phase = PH_CODE_HI;
                        end
                    end
                    PH_CODE_HI: begin
                        n_code = v_code;
                        if (i_data_byte[7:2] == SKIP_PREFIX) begin
                            n_skip  = {i_data_byte[1:0], r_code[7:0]};
                            if (n_skip == '0) begin
                                n_skip = SKIP_W'(1);
                            end
                            n_phase = PH_SKIP;
                        end else if (!i_data_byte[7] ||
                                     (r_pixel_mode && (i_data_byte >= EIGHT_CODE_HI))) begin
                            n_phase = PH_COLORS;
                            n_k     = '0;
                        end else begin
                            w_push.valid    = 1'b1;
                            w_push.cmd.kind = KIND_FILL;
                            w_push.cmd.fill = r_pixel_mode ? {16'h0000, r_code[7:0]}
                                                           : widen555(v_code);
                            adv_en  = 1'b1;
                            adv_n   = SKIP_W'(1);
                            n_col   = adv_col;
                            n_row   = adv_row;
                            n_phase = PH_CODE_LO;
                            if (adv_drop) begin
                                n_active = 1'b0;
                            end
                        end
                    end
                    PH_COLORS: begin
                        if (r_pixel_mode) begin
                            n_colors[r_k[2:0]] = {8'h00, i_data_byte};
                            if (!r_code[15]) begin
                                v_kind = KIND_TWO;
                                v_need = 5'd2;
                            end else begin
                                v_kind = KIND_EIGHT;
                                v_need = 5'd8;
                            end
                        end else begin
                            if (r_k[0]) begin
                                n_colors[r_k[3:1]][15:8] = i_data_byte;
                            end else begin
                                n_colors[r_k[3:1]][7:0] = i_data_byte;
                            end
                            if ((v_k_new >= 5'd4) && r_colors[0][15]) begin
                                v_kind = KIND_EIGHT;
                                v_need = 5'd16;
                            end
                        end
                        if (v_k_new >= v_need) begin
                            w_push.valid      = 1'b1;
                            w_push.cmd.kind   = v_kind;
                            w_push.cmd.colors = n_colors;
                            adv_en  = 1'b1;
                            adv_n   = SKIP_W'(1);
                            n_col   = adv_col;
                            n_row   = adv_row;
                            n_phase = PH_CODE_LO;
                            if (adv_drop) begin
                                n_active = 1'b0;
                            end
                        end else begin
                            n_k = v_k_new[3:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_cmd_push = w_push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_wide <= CFG_W'(80);
            r_blocks_high <= CFG_W'(60);
            r_pixel_mode  <= 1'b0;
            r_phase       <= PH_CODE_LO;
            r_k           <= '0;
            r_code        <= '0;
            r_col         <= '0;
            r_row         <= '0;
            r_skip        <= '0;
            r_active      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_BLOCKS_WIDE: r_blocks_wide <= i_cfg_data;
                    REG_BLOCKS_HIGH: r_blocks_high <= i_cfg_data;
                    REG_PIXEL_MODE:  r_pixel_mode  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            r_phase  <= n_phase;
            r_k      <= n_k;
            r_code   <= n_code;
            r_col    <= n_col;
            r_row    <= n_row;
            r_skip   <= n_skip;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_colors <= n_colors;
    end

endmodule

// ===== rtl/core/cvq_queue.sv =====
// ----------------------------------------------------------------------------
// Color-block VQ decoder command queue
// Short queue of block commands between the parser and the pixel generator.
// ----------------------------------------------------------------------------
module cvq_queue import cvq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_push i_push,
    input  logic      i_pop,
    output t_cmd      o_head,
    output logic      o_empty,
    output logic      o_full
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            w_wr;
    logic            w_rd;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign w_wr    = i_push.valid && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CntW'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

endmodule

// ===== rtl/core/cvq_back.sv =====
// ----------------------------------------------------------------------------
// Color-block VQ decoder pixel generator
// Expands the oldest block command into sixteen registered pixel writes.
// ----------------------------------------------------------------------------
module cvq_back import cvq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_head,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    output logic               empty,
    input  logic               pop,
    output logic [COORD_W-1:0] o_pixel_x,
    output logic [COORD_W-1:0] o_pixel_y,
    output logic [VALUE_W-1:0] o_pixel_value,
    output logic               o_block_last
);

    logic [3:0]         r_idx;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [VALUE_W-1:0] r_value;
    logic               r_last;

    logic               w_adv;
    logic [2:0]         w_sel;
    logic [15:0]        w_color;
    logic [VALUE_W-1:0] w_value;
    logic               w_eight;
    logic [1:0]         w_yoff;

    assign w_adv   = !i_q_empty && (!r_out_valid || pop);
    assign o_q_pop = w_adv && (r_idx == 4'hF);
    assign w_eight = (i_head.kind == KIND_EIGHT);
    assign w_sel   = {w_eight && r_idx[3], w_eight && r_idx[1], !i_head.flags[r_idx]};
    assign w_color = i_head.colors[w_sel];
    assign w_yoff  = ~r_idx[3:2];

    always_comb begin
        case (i_head.kind)
            KIND_FILL: w_value = i_head.fill;
            KIND_TWO, KIND_EIGHT: begin
                w_value = i_head.mode ? {16'h0000, w_color[7:0]} : widen555(w_color);
            end
            default: w_value = i_head.fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_idx       <= r_idx + 4'd1;
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x     <= i_head.xbase + COORD_W'(r_idx[1:0]);
            r_y     <= i_head.ybase + COORD_W'(w_yoff);
            r_value <= w_value;
            r_last  <= (r_idx == 4'hF);
        end
    end

    assign empty         = !r_out_valid;
    assign o_pixel_x     = r_x;
    assign o_pixel_y     = r_y;
    assign o_pixel_value = r_value;
    assign o_block_last  = r_last;

endmodule

// ===== rtl/core/color_block_vq_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// Color-block VQ frame decoder
// Decodes a stream of compressed frame bytes into pixel writes of 4x4 blocks.
// ----------------------------------------------------------------------------
// The input side is a queue: a byte transfers on a clock edge with push high
// and full low, frame_start marking the first byte of a frame. The result
// side is a queue too: while empty is low one pixel write is on the ports
// and it transfers on an edge with pop high. Configuration is a plain write
// port with no wait states. A byte that completes a block writes its command
// into the queue; the pixel generator turns it into sixteen registered pixel
// writes, one pixel per cycle while pop is high. The parser takes one byte per
// cycle while the two-entry command queue has room and no skip is pending, so
// it runs ahead by up to two blocks. A skip code holds full high while the
// parser steps over the skipped blocks row by row. When the receiver stalls,
// the output register holds and the queue fills, and then full rises. Reset
// restores the register defaults, empties the queue and the output and leaves
// the decoder idle until a byte with frame_start arrives.
// ----------------------------------------------------------------------------
module color_block_vq_frame_decoder import cvq_pkg::*; #(
    parameter int MAX_BLOCKS_WIDE = 512,
    parameter int MAX_BLOCKS_HIGH = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_frame_start,
    output logic                  empty,
    input  logic                  pop,
    output logic [COORD_W-1:0]    o_pixel_x,
    output logic [COORD_W-1:0]    o_pixel_y,
    output logic [VALUE_W-1:0]    o_pixel_value,
    output logic                  o_block_last
);

    t_cmd_push w_cmd_push;
    t_cmd      w_head;
    logic      w_q_empty;
    logic      w_q_full;
    logic      w_q_pop;

    cvq_front #(
        .MAX_BLOCKS_WIDE(MAX_BLOCKS_WIDE),
        .MAX_BLOCKS_HIGH(MAX_BLOCKS_HIGH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .i_data_byte  (i_data_byte),
        .i_frame_start(i_frame_start),
        .o_full       (full),
        .i_q_full     (w_q_full),
        .o_cmd_push   (w_cmd_push)
    );

    cvq_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_cmd_push),
        .i_pop  (w_q_pop),
        .o_head (w_head),
        .o_empty(w_q_empty),
        .o_full (w_q_full)
    );

    cvq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_q_empty    (w_q_empty),
        .o_q_pop      (w_q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_pixel_value(o_pixel_value),
        .o_block_last (o_block_last)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd_push.valid && w_q_full))
        else $error("Block command produced while the command queue is full.");

    a_last_pixel_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_block_last) |-> (o_pixel_x[1:0] == 2'b11 && o_pixel_y[1:0] == 2'b00))
        else $error("Last pixel of a block is not its top right corner.");

    a_pop_only_at_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |=> (!empty && o_block_last))
        else $error("Command retired without presenting the last pixel of its block.");
`endif

endmodule
